// ===== rtl/ucs_pkg.sv =====
// Package for the endpoint 0 control sequencer: codes, payload structs and
// the queue sizes shared by the front, queue, back and top level files.
// Depends on nothing.
package ucs_pkg;

  // Queue sizes
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  // Event codes
  localparam logic [2:0] CMD_BUS_RESET = 3'd0;
  localparam logic [2:0] CMD_SETUP     = 3'd1;
  localparam logic [2:0] CMD_POLL      = 3'd2;
  localparam logic [2:0] CMD_IN_DONE   = 3'd3;

  // Action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_DATA   = 3'd1;
  localparam logic [2:0] ACT_ZLP    = 3'd2;
  localparam logic [2:0] ACT_ADDR   = 3'd3;
  localparam logic [2:0] ACT_CONFIG = 3'd4;
  localparam logic [2:0] ACT_MOUSE  = 3'd5;

  // Control stage codes as seen on the result port
  localparam logic [2:0] STC_SETUP        = 3'd0;
  localparam logic [2:0] STC_DATA_IN      = 3'd1;
  localparam logic [2:0] STC_DATA_IN_IDLE = 3'd2;
  localparam logic [2:0] STC_DATA_IN_ZERO = 3'd3;
  localparam logic [2:0] STC_STATUS_OUT   = 3'd4;
  localparam logic [2:0] STC_STATUS_IN    = 3'd5;

  // Setup request decode
  localparam logic [6:0] SEL_STD_DEVICE  = 7'h00;
  localparam logic [6:0] SEL_STD_IFACE   = 7'h01;
  localparam logic [6:0] SEL_CLASS_IFACE = 7'h21;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_SET_IDLE    = 8'h0A;
  localparam logic [7:0] DT_DEVICE       = 8'h01;
  localparam logic [7:0] DT_CONFIG       = 8'h02;
  localparam logic [7:0] DT_HID_REPORT   = 8'h22;

  // Descriptor sources
  localparam logic [1:0] SRC_DEVICE = 2'd0;
  localparam logic [1:0] SRC_CONFIG = 2'd1;
  localparam logic [1:0] SRC_REPORT = 2'd2;

  // Device modes
  localparam logic [1:0] MODE_DEFAULT    = 2'd0;
  localparam logic [1:0] MODE_ADDRESSED  = 2'd1;
  localparam logic [1:0] MODE_CONFIGURED = 2'd2;

  localparam logic [3:0] EP_MASK = 4'hF;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_MAX_PACKET = 2'd0;
  localparam logic [1:0]  CFG_INT_EP     = 2'd1;
  localparam logic [1:0]  CFG_REPORT_LEN = 2'd2;
  localparam logic [6:0]  MPS_RESET      = 7'd64;
  localparam logic [3:0]  INT_EP_RESET   = 4'd1;
  localparam logic [15:0] REPORT_LEN_RESET = 16'd52;

  typedef enum logic [5:0] {
    STG_SETUP        = 6'b000001,
    STG_DATA_IN      = 6'b000010,
    STG_DATA_IN_IDLE = 6'b000100,
    STG_DATA_IN_ZERO = 6'b001000,
    STG_STATUS_OUT   = 6'b010000,
    STG_STATUS_IN    = 6'b100000
  } stage_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BUS_RESET,
    OP_GET_DESC,
    OP_SET_ADDR,
    OP_SET_CONFIG,
    OP_SET_IDLE,
    OP_REPORT_DESC,
    OP_POLL,
    OP_IN_DONE
  } op_kind_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic [3:0]  endpoint;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  target_endpoint;
    logic [1:0]  data_source;
    logic [15:0] data_offset;
    logic [6:0]  data_length;
    logic [6:0]  new_address;
    logic [1:0]  usb_state;
    logic [2:0]  stage;
    logic [7:0]  config_value;
    logic        last;
  } out_t;

  // Classified event between front and back
  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] len;
    logic [7:0]  arg;
    logic [1:0]  src;
    logic [3:0]  ep;
  } op_t;

  // One or two results written by the back part in a cycle
  typedef struct packed {
    logic valid;
    logic two;
    out_t item0;
    out_t item1;
  } res_pair_t;

  function automatic logic [2:0] stage_code(stage_t s);
    logic [2:0] c;
    unique case (s)
      STG_SETUP:        c = STC_SETUP;
      STG_DATA_IN:      c = STC_DATA_IN;
      STG_DATA_IN_IDLE: c = STC_DATA_IN_IDLE;
      STG_DATA_IN_ZERO: c = STC_DATA_IN_ZERO;
      STG_STATUS_OUT:   c = STC_STATUS_OUT;
      STG_STATUS_IN:    c = STC_STATUS_IN;
      default:          c = STC_SETUP;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ucs_front.sv =====
// Front part: classifies an incoming event and its setup bytes into an op.
// Depends on ucs_pkg.
module ucs_front import ucs_pkg::*; (
  input  in_t in_data,
  output op_t op
);

  logic [6:0] sel;
  logic [7:0] dtype;

  assign sel   = in_data.request_type[6:0];
  assign dtype = in_data.request_value[15:8];

  always_comb begin
    op      = '0;
    op.kind = OP_NONE;
    op.len  = in_data.request_length;
    op.ep   = in_data.endpoint;
    priority if (in_data.cmd == CMD_BUS_RESET) begin
      op.kind = OP_BUS_RESET;
    end else if (in_data.cmd == CMD_SETUP) begin
      priority if (sel == SEL_STD_DEVICE) begin
        priority if (in_data.request_code == REQ_GET_DESC) begin
          if (dtype == DT_DEVICE || dtype == DT_CONFIG) begin
            op.kind = OP_GET_DESC;
            op.src  = (dtype == DT_DEVICE) ? SRC_DEVICE : SRC_CONFIG;
          end
        end else if (in_data.request_code == REQ_SET_ADDRESS) begin
          op.kind = OP_SET_ADDR;
          op.arg  = {1'b0, in_data.request_value[6:0]};
        end else if (in_data.request_code == REQ_SET_CONFIG) begin
          op.kind = OP_SET_CONFIG;
          op.arg  = in_data.request_value[7:0];
        end else begin
        end
      end else if (sel == SEL_CLASS_IFACE) begin
        if (in_data.request_code == REQ_SET_IDLE) op.kind = OP_SET_IDLE;
      end else if (sel == SEL_STD_IFACE) begin
        if (dtype == DT_HID_REPORT) op.kind = OP_REPORT_DESC;
      end else begin
      end
    end else if (in_data.cmd == CMD_POLL) begin
      op.kind = OP_POLL;
    end else if (in_data.cmd == CMD_IN_DONE) begin
      op.kind = OP_IN_DONE;
    end else begin
      // OUT-complete and unused codes: leave as none
    end
  end

endmodule

// ===== rtl/ucs_opq.sv =====
// Op queue between front and back: a few classified events in flight.
// Depends on ucs_pkg.
module ucs_opq import ucs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  op_in,
  input  logic pop,
  output op_t  op_out,
  output logic full,
  output logic empty
);

  op_t              mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_AW:0]   count_r, count_nxt;

  assign full   = (count_r == (OQ_AW+1)'(OQ_DEPTH));
  assign empty  = (count_r == '0);
  assign op_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + OQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + OQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (OQ_AW+1)'(push) - (OQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= op_in;
  end

endmodule

// ===== rtl/ucs_back.sv =====
// Back part: control transfer state, configuration registers, and the
// result items for each op. Depends on ucs_pkg.
module ucs_back import ucs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  op_t         op,
  input  logic        op_valid,
  input  logic        room,
  output logic        op_pop,
  output res_pair_t   res
);

  logic [6:0]  mps_r;
  logic [3:0]  int_ep_r;
  logic [15:0] rdl_r;

  stage_t      stage_r, stage_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [1:0]  src_r, src_nxt;
  logic [7:0]  config_r, config_nxt;

  logic        fire;
  logic [15:0] mps_ext;
  logic [15:0] size;
  logic [15:0] remain_dec;
  logic        used0;
  logic        two;
  logic [2:0]  act0, act1;
  logic [3:0]  ep0, ep1;
  logic [6:0]  addr0;

  assign fire    = op_valid && room;
  assign op_pop  = fire;
  assign mps_ext = {9'd0, mps_r};
  assign size    = (remain_r < mps_ext) ? remain_r : mps_ext;
  assign remain_dec = remain_r - size;

  always_comb begin
    stage_nxt  = stage_r;
    mode_nxt   = mode_r;
    remain_nxt = remain_r;
    offset_nxt = offset_r;
    src_nxt    = src_r;
    config_nxt = config_r;
    used0 = 1'b0;
    two   = 1'b0;
    act0  = ACT_NONE;
    act1  = ACT_NONE;
    ep0   = '0;
    ep1   = '0;
    addr0 = '0;
    res   = '0;

    unique case (op.kind)
      OP_BUS_RESET: begin
        remain_nxt = '0;
        config_nxt = '0;
        mode_nxt   = MODE_DEFAULT;
        stage_nxt  = STG_SETUP;
        act0       = ACT_ADDR;
      end
      OP_GET_DESC: begin
        src_nxt    = op.src;
        offset_nxt = '0;
        remain_nxt = op.len;
        stage_nxt  = STG_DATA_IN;
      end
      OP_REPORT_DESC: begin
        src_nxt    = SRC_REPORT;
        offset_nxt = '0;
        remain_nxt = rdl_r;
        stage_nxt  = STG_DATA_IN;
      end
      OP_SET_ADDR: begin
        act0      = ACT_ADDR;
        addr0     = op.arg[6:0];
        mode_nxt  = MODE_ADDRESSED;
        stage_nxt = STG_STATUS_IN;
      end
      OP_SET_CONFIG: begin
        config_nxt = op.arg;
        act0       = ACT_CONFIG;
        ep0        = int_ep_r & EP_MASK;
        act1       = ACT_ZLP;
        ep1        = int_ep_r & EP_MASK;
        two        = 1'b1;
        mode_nxt   = MODE_CONFIGURED;
        stage_nxt  = STG_STATUS_IN;
      end
      OP_SET_IDLE: begin
        stage_nxt = STG_STATUS_IN;
      end
      OP_POLL: begin
        priority if (stage_r == STG_DATA_IN) begin
          act0       = ACT_DATA;
          remain_nxt = remain_dec;
          offset_nxt = offset_r + size;
          // Full last packet needs a zero-length packet to close the data stage
          if (remain_dec != '0)   stage_nxt = STG_DATA_IN_IDLE;
          else if (size == mps_ext) stage_nxt = STG_DATA_IN_ZERO;
          else                    stage_nxt = STG_STATUS_OUT;
        end else if (stage_r == STG_STATUS_OUT) begin
          stage_nxt = STG_SETUP;
        end else if (stage_r == STG_STATUS_IN) begin
          act0      = ACT_ZLP;
          stage_nxt = STG_SETUP;
        end else begin
          // other stages: hold
        end
      end
      OP_IN_DONE: begin
        priority if (remain_r != '0) begin
          stage_nxt = STG_DATA_IN;
        end else if (stage_r == STG_DATA_IN_ZERO) begin
          act0      = ACT_ZLP;
          used0     = 1'b1;
          stage_nxt = STG_STATUS_OUT;
        end else begin
        end
        if (op.ep == (int_ep_r & EP_MASK)) begin
          if (used0) begin
            act1 = ACT_MOUSE;
            ep1  = op.ep;
            two  = 1'b1;
          end else begin
            act0 = ACT_MOUSE;
            ep0  = op.ep;
          end
        end
      end
      default: begin
      end
    endcase

    res.valid                 = fire;
    res.two                   = two;
    res.item0.action          = act0;
    res.item0.target_endpoint = ep0;
    res.item0.new_address     = addr0;
    if (act0 == ACT_DATA) begin
      res.item0.data_source = src_r;
      res.item0.data_offset = offset_r;
      res.item0.data_length = size[6:0];
    end
    res.item0.usb_state       = mode_nxt;
    res.item0.stage           = stage_code(stage_nxt);
    res.item0.config_value    = config_nxt;
    res.item0.last            = !two;
    res.item1.action          = act1;
    res.item1.target_endpoint = ep1;
    res.item1.usb_state       = mode_nxt;
    res.item1.stage           = stage_code(stage_nxt);
    res.item1.config_value    = config_nxt;
    res.item1.last            = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= STG_SETUP;
      mode_r   <= MODE_DEFAULT;
      remain_r <= '0;
      offset_r <= '0;
      src_r    <= SRC_DEVICE;
      config_r <= '0;
    end else if (fire) begin
      stage_r  <= stage_nxt;
      mode_r   <= mode_nxt;
      remain_r <= remain_nxt;
      offset_r <= offset_nxt;
      src_r    <= src_nxt;
      config_r <= config_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mps_r    <= MPS_RESET;
      int_ep_r <= INT_EP_RESET;
      rdl_r    <= REPORT_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_MAX_PACKET: mps_r    <= cfg_data[6:0];
        CFG_INT_EP:     int_ep_r <= cfg_data[3:0];
        CFG_REPORT_LEN: rdl_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  a_packet_within_mps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op.kind == OP_POLL && stage_r == STG_DATA_IN
      |-> res.item0.data_length <= mps_r)
    else $error("data packet longer than max packet size");

  a_bus_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op.kind == OP_BUS_RESET
      |=> mode_r == MODE_DEFAULT && remain_r == '0 && stage_r == STG_SETUP)
    else $error("bus reset did not clear transfer state");

endmodule

// ===== rtl/ucs_resq.sv =====
// Result queue: takes one or two items a cycle from the back part and
// hands the oldest to the result port. Depends on ucs_pkg.
module ucs_resq import ucs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t wr,
  output logic      room,
  input  logic      pop,
  output logic      empty,
  output out_t      head
);

  out_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_AW:0]   count_r, count_nxt;
  logic [RQ_AW:0]   wr_cnt;
  logic             do_pop;
  logic [RQ_AW-1:0] wr_ptr_p1;

  assign empty     = (count_r == '0);
  assign room      = (count_r <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && !empty;
  assign wr_ptr_p1 = wr_ptr_r + RQ_AW'(1);

  always_comb begin
    wr_cnt     = wr.valid ? (wr.two ? (RQ_AW+1)'(2) : (RQ_AW+1)'(1)) : '0;
    wr_ptr_nxt = wr_ptr_r + wr_cnt[RQ_AW-1:0];
    rd_ptr_nxt = do_pop ? rd_ptr_r + RQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + wr_cnt - (RQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) mem_r[wr_ptr_r] <= wr.item0;
    if (wr.valid && wr.two) mem_r[wr_ptr_p1] <= wr.item1;
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue overfilled");

  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr.valid |-> count_r <= (RQ_AW+1)'(RQ_DEPTH - 2))
    else $error("results written without room for two");

endmodule

// ===== rtl/usb_control_endpoint_sequencer_core.sv =====
// Top level of the endpoint 0 control sequencer: front classifier, op queue,
// back executor and result queue. Depends on ucs_pkg and the ucs_* modules.
//
//   channel   direction  handshake            payload
//   in_       event in   in_push / in_full    in_data   (in_t)
//   out_      result out out_pop / out_empty  out_data  (out_t)
//   cfg_      reg write  cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One event is accepted per cycle while the op queue has space. The back part
// executes one op per cycle whenever the result queue has room for two items,
// so the sustained rate is one event per cycle, bounded by how fast results
// (one or two per event) are popped. An accepted event is written into the op
// queue and executed once it heads that queue and the result queue has room;
// its results are written into the result queue, whose head is on out_data.
// Reset is synchronous and active low; it empties both queues and restores
// the registers to their defaults. Configuration writes are always taken
// (cfg_ready stays high) and an index beyond the register list is dropped.
module usb_control_endpoint_sequencer_core import ucs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // event requests
  input  logic        in_push,
  output logic        in_full,
  input  in_t         in_data,
  // result requests
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  op_t       front_op;
  op_t       head_op;
  logic      oq_push;
  logic      oq_empty;
  logic      op_pop;
  logic      rq_room;
  res_pair_t res;

  // Registers are always writable: the back part reads them only when ops run
  assign cfg_ready = 1'b1;

  // Accept a request whenever the op queue has space
  assign oq_push = in_push && !in_full;

  ucs_front u_front (
    .in_data (in_data),
    .op      (front_op)
  );

  ucs_opq u_opq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (oq_push),
    .op_in  (front_op),
    .pop    (op_pop),
    .op_out (head_op),
    .full   (in_full),
    .empty  (oq_empty)
  );

  // Advance the head op only when both of its possible results fit
  ucs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (head_op),
    .op_valid  (!oq_empty),
    .room      (rq_room),
    .op_pop    (op_pop),
    .res       (res)
  );

  // Hold results here until popped; the back part keeps running meanwhile while room for two remains
  ucs_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res),
    .room  (rq_room),
    .pop   (out_pop),
    .empty (out_empty),
    .head  (out_data)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the endpoint 0 control sequencer core.
// Holds its own model of the stage machine and compares every popped result.
// Depends on ucs_pkg and usb_control_endpoint_sequencer_core.
module tb;
  import ucs_pkg::*;

  // OUT-complete has no package constant; codes above it are undefined events
  localparam logic [2:0] CMD_OUT_DONE = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_t         in_data;
  logic        out_empty;
  logic        out_pop;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  usb_control_endpoint_sequencer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies kept by the bench
  logic [6:0]  mps_reg;
  logic [3:0]  int_ep_reg;
  logic [15:0] report_len_reg;

  // Sequencer state kept by the bench
  logic [2:0]  ep0_stage;
  logic [1:0]  dev_mode;
  logic [15:0] bytes_left;
  logic [15:0] byte_pos;
  logic [1:0]  desc_src;
  logic [7:0]  cfg_value;

  out_t        pending_actions[$];   // results still owed by the block
  int unsigned mismatches;
  int unsigned requests_sent;
  bit          idle_on;              // random gaps on both sides
  int          hold_left;            // long receiver hold-off, counted by the receiver

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic string describe(out_t r);
    return $sformatf({"act=%0d ep=%0d src=%0d off=%0d len=%0d addr=%0d ",
                      "st=%0d stg=%0d cfg=%0d last=%0d"},
                     r.action, r.target_endpoint, r.data_source, r.data_offset,
                     r.data_length, r.new_address, r.usb_state, r.stage,
                     r.config_value, r.last);
  endfunction

  // Work out the actions one accepted event causes and queue them in order
  task automatic advance_sequencer(input in_t ev);
    out_t        acts[2];
    int          n;
    logic [6:0]  sel;
    logic [7:0]  dtype;
    logic [15:0] chunk;
    begin
      acts[0] = '0;
      acts[1] = '0;
      n       = 0;
      sel     = ev.request_type[6:0];
      dtype   = ev.request_value[15:8];
      case (ev.cmd)
        CMD_BUS_RESET: begin
          bytes_left     = '0;
          cfg_value      = '0;
          dev_mode       = MODE_DEFAULT;
          ep0_stage      = STC_SETUP;
          acts[0].action = ACT_ADDR;
          n = 1;
        end
        CMD_SETUP: begin
          if (sel == SEL_STD_DEVICE) begin
            if (ev.request_code == REQ_GET_DESC) begin
              if (dtype == DT_DEVICE || dtype == DT_CONFIG) begin
                desc_src   = (dtype == DT_DEVICE) ? SRC_DEVICE : SRC_CONFIG;
                byte_pos   = '0;
                bytes_left = ev.request_length;   // wLength taken as it is
                ep0_stage  = STC_DATA_IN;
              end
            end else if (ev.request_code == REQ_SET_ADDRESS) begin
              acts[0].action      = ACT_ADDR;
              acts[0].new_address = ev.request_value[6:0];
              n = 1;
              dev_mode  = MODE_ADDRESSED;
              ep0_stage = STC_STATUS_IN;
            end else if (ev.request_code == REQ_SET_CONFIG) begin
              cfg_value = ev.request_value[7:0];
              acts[0].action          = ACT_CONFIG;
              acts[0].target_endpoint = int_ep_reg & EP_MASK;
              acts[1].action          = ACT_ZLP;
              acts[1].target_endpoint = int_ep_reg & EP_MASK;
              n = 2;
              dev_mode  = MODE_CONFIGURED;
              ep0_stage = STC_STATUS_IN;
            end
          end else if (sel == SEL_CLASS_IFACE) begin
            if (ev.request_code == REQ_SET_IDLE) ep0_stage = STC_STATUS_IN;
          end else if (sel == SEL_STD_IFACE) begin
            // only the descriptor type matters here, not the request code
            if (dtype == DT_HID_REPORT) begin
              desc_src   = SRC_REPORT;
              byte_pos   = '0;
              bytes_left = report_len_reg;
              ep0_stage  = STC_DATA_IN;
            end
          end
        end
        CMD_POLL: begin
          if (ep0_stage == STC_DATA_IN) begin
            chunk = (bytes_left < {9'd0, mps_reg}) ? bytes_left : {9'd0, mps_reg};
            acts[0].action      = ACT_DATA;
            acts[0].data_source = desc_src;
            acts[0].data_offset = byte_pos;
            acts[0].data_length = chunk[6:0];
            n = 1;
            bytes_left = bytes_left - chunk;
            byte_pos   = byte_pos + chunk;
            ep0_stage  = STC_DATA_IN_IDLE;
            // a full final packet must be followed by a zero-length one
            if (bytes_left == 16'd0)
              ep0_stage = (chunk == {9'd0, mps_reg}) ? STC_DATA_IN_ZERO : STC_STATUS_OUT;
          end else if (ep0_stage == STC_STATUS_OUT) begin
            ep0_stage = STC_SETUP;
          end else if (ep0_stage == STC_STATUS_IN) begin
            acts[0].action = ACT_ZLP;
            n = 1;
            ep0_stage = STC_SETUP;
          end
        end
        CMD_IN_DONE: begin
          if (bytes_left != 16'd0) begin
            ep0_stage = STC_DATA_IN;
          end else if (ep0_stage == STC_DATA_IN_ZERO) begin
            acts[0].action = ACT_ZLP;
            n = 1;
            ep0_stage = STC_STATUS_OUT;
          end
          if (ev.endpoint == (int_ep_reg & EP_MASK)) begin
            acts[n].action          = ACT_MOUSE;
            acts[n].target_endpoint = ev.endpoint;
            n++;
          end
        end
        default: ;   // OUT-complete and undefined codes change nothing
      endcase
      if (n == 0) n = 1;
      for (int k = 0; k < n; k++) begin
        acts[k].usb_state    = dev_mode;
        acts[k].stage        = ep0_stage;
        acts[k].config_value = cfg_value;
        acts[k].last         = (k == n - 1);
        pending_actions.push_back(acts[k]);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking: compare each popped result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_actions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %s", describe(out_data));
      end else begin
        want = pending_actions.pop_front();
        if (out_data.action          !== want.action          ||
            out_data.target_endpoint !== want.target_endpoint ||
            out_data.data_source     !== want.data_source     ||
            out_data.data_offset     !== want.data_offset     ||
            out_data.data_length     !== want.data_length     ||
            out_data.new_address     !== want.new_address     ||
            out_data.usb_state       !== want.usb_state       ||
            out_data.stage           !== want.stage           ||
            out_data.config_value    !== want.config_value    ||
            out_data.last            !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch at %0t\n  expected %s\n  actual   %s",
                     $time, describe(want), describe(out_data));
        end
      end
    end
  end

  // Receiver: pop at every falling edge unless holding off or in a random burst
  initial begin : receiver
    int burst;
    burst   = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        burst = $urandom_range(1, 18) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  // Offer one event, hold it until the block takes it, then predict
  task automatic send_event(input in_t ev);
    int gap;
    begin
      if (idle_on && $urandom_range(0, 11) == 0) begin
        gap = $urandom_range(1, 18);
        repeat (gap) begin
          @(negedge clk);
          in_push <= 1'b0;
        end
      end
      @(negedge clk);
      in_push <= 1'b1;
      in_data <= ev;
      do @(posedge clk); while (in_full);
      advance_sequencer(ev);
      requests_sent++;
    end
  endtask

  // Drop the request line and wait until every owed result has been popped
  task automatic wait_for_drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    wait_for_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_PACKET: mps_reg        = val[6:0];
      CFG_INT_EP:     int_ep_reg     = val[3:0];
      CFG_REPORT_LEN: report_len_reg = val;
      default: ;   // index beyond the register list is dropped
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all three registers, with random junk in the unused upper bits
  task automatic apply_settings(input logic [6:0] mps, input logic [3:0] ep,
                                input logic [15:0] rlen);
    logic [15:0] v;
    begin
      v = 16'($urandom);
      v[6:0] = mps;
      write_register(CFG_MAX_PACKET, v);
      v = 16'($urandom);
      v[3:0] = ep;
      write_register(CFG_INT_EP, v);
      write_register(CFG_REPORT_LEN, rlen);
    end
  endtask

  function automatic in_t random_event();
    in_t ev;
    ev.cmd            = 3'($urandom_range(0, 7));
    ev.request_type   = 8'($urandom);
    ev.request_code   = 8'($urandom);
    ev.request_value  = 16'($urandom);
    ev.request_length = 16'($urandom);
    ev.endpoint       = 4'($urandom);
    return ev;
  endfunction

  function automatic in_t setup_request(input logic [7:0] rt, input logic [7:0] code,
                                        input logic [15:0] value, input logic [15:0] length);
    in_t ev;
    ev = '0;
    ev.cmd            = CMD_SETUP;
    ev.request_type   = rt;
    ev.request_code   = code;
    ev.request_value  = value;
    ev.request_length = length;
    return ev;
  endfunction

  function automatic in_t bus_event(input logic [2:0] cmd, input logic [3:0] ep);
    in_t ev;
    ev = '0;
    ev.cmd      = cmd;
    ev.endpoint = ep;
    return ev;
  endfunction

  // wLength for a descriptor read: mostly short, some exact packet multiples
  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'(mps_reg * $urandom_range(1, 3));
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  // One control transfer: a setup request, then polls and IN-completes as the
  // stage asks, with the odd stray event thrown in to break the sequence
  task automatic run_control_transfer();
    in_t ev;
    int  steps;
    begin
      ev = random_event();
      ev.cmd = CMD_SETUP;
      ev.request_type[6:0] = SEL_STD_DEVICE;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          ev.request_code          = REQ_GET_DESC;
          ev.request_value[15:8]   = $urandom_range(0, 1) ? DT_DEVICE : DT_CONFIG;
          ev.request_length        = pick_length();
        end
        3, 4: begin
          ev.request_type[6:0]     = SEL_STD_IFACE;
          ev.request_value[15:8]   = DT_HID_REPORT;
        end
        5:  ev.request_code = REQ_SET_ADDRESS;
        6:  ev.request_code = REQ_SET_CONFIG;
        7: begin
          ev.request_type[6:0] = SEL_CLASS_IFACE;
          ev.request_code      = REQ_SET_IDLE;
        end
        8:  ev.cmd = CMD_BUS_RESET;
        default: ev.request_type = 8'($urandom);   // malformed or unsupported setup
      endcase
      send_event(ev);
      steps = 0;
      while (ep0_stage != STC_SETUP && steps < 40) begin
        ev = random_event();
        if (ep0_stage == STC_DATA_IN || ep0_stage == STC_STATUS_OUT ||
            ep0_stage == STC_STATUS_IN)
          ev.cmd = CMD_POLL;
        else
          ev.cmd = CMD_IN_DONE;
        if ($urandom_range(0, 3) == 0) ev.endpoint = int_ep_reg;
        if ($urandom_range(0, 11) == 0) ev = random_event();
        send_event(ev);
        steps++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every request kind and stage transition at the reset register values
  task automatic test_directed_requests();
    send_event(bus_event(CMD_BUS_RESET, 4'd0));
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0100, 16'd18));
    send_event(bus_event(CMD_POLL, 4'd0));          // short packet, then status-out
    send_event(bus_event(CMD_IN_DONE, 4'd1));       // mouse report only
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0200, 16'hFFFF));
    send_event(bus_event(CMD_POLL, 4'd0));
    send_event(bus_event(CMD_IN_DONE, 4'd5));       // bytes remain: back to data-in
    send_event(setup_request(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF));
    send_event(bus_event(CMD_POLL, 4'd0));          // status-in zero-length packet
    send_event(setup_request(8'h00, REQ_SET_CONFIG, 16'hFFFF, 16'd0));
    send_event(setup_request(8'hA1, REQ_SET_IDLE, 16'd0, 16'd0));
    send_event(bus_event(CMD_POLL, 4'd0));
    send_event(setup_request(8'h81, REQ_GET_DESC, {DT_HID_REPORT, 8'h00}, 16'd0));
    send_event(bus_event(CMD_POLL, 4'd0));
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0300, 16'd8));   // unknown type
    send_event(setup_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));        // unknown request
    send_event(bus_event(CMD_OUT_DONE, 4'hF));
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0100, 16'd64));
    send_event(bus_event(CMD_POLL, 4'd0));          // full packet: zero-length owed
    send_event(bus_event(CMD_IN_DONE, 4'hF));
    send_event(bus_event(CMD_POLL, 4'd0));
  endtask

  // Zero and largest packet size, interrupt endpoint 0 and length extremes
  task automatic test_packet_size_extremes();
    apply_settings(7'd0, 4'd0, 16'hFFFF);
    write_register(2'd3, 16'hFFFF);                 // out-of-range index, dropped
    send_event(setup_request(8'h01, 8'h00, {DT_HID_REPORT, 8'h00}, 16'd0));
    send_event(bus_event(CMD_POLL, 4'd0));          // empty packet, bytes still left
    send_event(bus_event(CMD_IN_DONE, 4'd0));       // data-in again plus mouse report
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0100, 16'd0));
    send_event(bus_event(CMD_POLL, 4'd0));          // empty equals packet size
    send_event(bus_event(CMD_IN_DONE, 4'd0));       // zero-length plus mouse report
    apply_settings(7'd127, 4'd15, 16'd0);
    send_event(setup_request(8'h81, REQ_GET_DESC, {DT_HID_REPORT, 8'h00}, 16'd0));
    send_event(bus_event(CMD_POLL, 4'd0));
    send_event(setup_request(8'h80, REQ_GET_DESC, 16'h0200, 16'd127));
    send_event(bus_event(CMD_POLL, 4'd0));
  endtask

  // Stop popping for a long stretch while events keep coming, so both
  // queues fill and the input stalls
  task automatic test_backpressure();
    wait_for_drain();
    hold_left = 300;
    repeat (30) run_control_transfer();
    wait_for_drain();
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    in_t ev;
    begin
      goal = requests_sent + count;
      while (requests_sent < goal) begin
        case ($urandom_range(0, 7))
          0:       send_event(random_event());
          1: begin
            ev = random_event();
            ev.cmd = CMD_IN_DONE;
            ev.endpoint = int_ep_reg;
            send_event(ev);
          end
          default: run_control_transfer();
        endcase
      end
    end
  endtask

  task automatic test_random_traffic();
    apply_settings(MPS_RESET, INT_EP_RESET, REPORT_LEN_RESET);
    random_phase(200);
    apply_settings(7'd8, 4'd15, 16'd0);
    random_phase(200);
    apply_settings(7'd127, 4'd1, 16'hFFFF);
    random_phase(150);
    apply_settings(7'd0, 4'd0, 16'd52);
    random_phase(100);
    repeat (2) begin
      apply_settings(7'($urandom_range(8, 64)), 4'($urandom_range(1, 15)),
                     16'($urandom_range(0, 300)));
      random_phase(150);
    end
    // last part runs flat out on both sides
    apply_settings(7'($urandom_range(8, 64)), 4'($urandom_range(1, 15)),
                   16'($urandom_range(0, 300)));
    idle_on = 1'b0;
    random_phase(200);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mps_reg        = MPS_RESET;
    int_ep_reg     = INT_EP_RESET;
    report_len_reg = REPORT_LEN_RESET;
    ep0_stage      = STC_SETUP;
    dev_mode       = MODE_DEFAULT;
    bytes_left     = '0;
    byte_pos       = '0;
    desc_src       = SRC_DEVICE;
    cfg_value      = '0;
    mismatches     = 0;
    requests_sent  = 0;
    idle_on        = 1'b1;
    hold_left      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_packet_size_extremes();
    test_backpressure();
    test_random_traffic();

    // hold on after the drain in case anything unasked for still comes out
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_actions.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ucs_pkg.sv
rtl/ucs_front.sv
rtl/ucs_opq.sv
rtl/ucs_back.sv
rtl/ucs_resq.sv
rtl/usb_control_endpoint_sequencer_core.sv
sim/tb.sv
